[design/lru_key_value_cache_assert.svh]
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// same-cycle implication
`define LKV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LKV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/lkv_pkg.sv]
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared constants, payload structs, opcodes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;
   localparam int KEY_W               = 32;
   localparam int VALUE_W             = 32;
   localparam int CAP_W               = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam int QUEUE_DEPTH         = 2;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } lkv_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_EXEC,
      ST_RESP
   } lkv_state_type;

   // request payload as seen on the ports
   typedef struct packed {
      logic                      opcode;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value_in;
   } lkv_req_type;

   // response payload as seen on the ports
   typedef struct packed {
      logic                      hit;
      logic signed [VALUE_W-1:0] value_out;
      logic                      evicted;
   } lkv_rsp_type;

   // decoded request carried through the queue
   typedef struct packed {
      lkv_op_type         op;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } lkv_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } lkv_qstat_type;

endpackage

`default_nettype wire

[design/lkv_ram.sv]
// ----------------------------------------------------------------------------
// LKV generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[design/lkv_front.sv]
// ----------------------------------------------------------------------------
// LKV front end
// Takes requests, decodes the opcode and hands them to the request queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire lkv_pkg::lkv_req_type   req_data,
   input  wire lkv_pkg::lkv_qstat_type q_stat,
   output logic                       push,
   output lkv_pkg::lkv_item_type      push_item
);

   import lkv_pkg::*;

   logic         pending_ff, pending_in;
   lkv_item_type item_ff, item_in;
   lkv_op_type   op_dec;
   logic         accept;

   // hold off only when the holding stage cannot drain
   assign busy   = pending_ff && q_stat.full;
   assign accept = start && !busy;
   assign push   = pending_ff && !q_stat.full;

   always_comb begin
      op_dec = req_data.opcode ? OP_PUT : OP_GET;

      pending_in = accept || (pending_ff && !push);

      item_in = item_ff;
      if (accept) begin
         item_in.op    = op_dec;
         item_in.key   = req_data.key;
         item_in.value = req_data.value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign push_item = item_ff;

endmodule

`default_nettype wire

[design/lkv_queue.sv]
// ----------------------------------------------------------------------------
// LKV request queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_queue #(
   parameter int DEPTH = lkv_pkg::QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire lkv_pkg::lkv_item_type push_item,
   input  wire logic                  pop,
   output lkv_pkg::lkv_item_type      pop_item,
   output lkv_pkg::lkv_qstat_type     q_stat
);

   import lkv_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   lkv_item_type   slot_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (cnt_ff == CW'(DEPTH));
   assign q_stat.empty = (cnt_ff == '0);

endmodule

`default_nettype wire

[design/lkv_back.sv]
// ----------------------------------------------------------------------------
// LKV back end
// Key compare, recency ranking, eviction and value store for one request
// at a time; a four-step sequencer drives the work.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_back #(
   parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEFAULT,
   localparam int CNTW       = $clog2(MAX_ENTRIES + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [lkv_pkg::CAP_W-1:0]   capacity,
   input  wire lkv_pkg::lkv_qstat_type      q_stat,
   input  wire lkv_pkg::lkv_item_type       pop_item,
   output logic                             pop,
   output logic                             rsp_valid,
   output lkv_pkg::lkv_rsp_type             rsp_data,
   output logic [CNTW-1:0]                  count
);

   import lkv_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int WW = 16;

   lkv_state_type    state_ff, state_in;
   lkv_item_type     item_ff, item_in;
   logic [KEY_W-1:0] key_ff [MAX_ENTRIES];
   logic [KEY_W-1:0] key_in [MAX_ENTRIES];
   logic [AW-1:0]    age_ff [MAX_ENTRIES];
   logic [AW-1:0]    age_in [MAX_ENTRIES];
   logic [CNTW-1:0]  count_ff, count_in;

   logic             hit_ff, hit_in;
   logic [AW-1:0]    hit_slot_ff, hit_slot_in;
   logic [AW-1:0]    hit_age_ff, hit_age_in;
   logic [AW-1:0]    lru_slot_ff, lru_slot_in;
   logic             full_ff, full_in;
   logic             evict_ff, evict_in;
   logic             get_hit_ff, get_hit_in;

   logic [CNTW-1:0]  count_m1;
   logic             srch_hit;
   logic [AW-1:0]    srch_slot, srch_age, srch_lru;
   logic [WW-1:0]    cap_eff;
   logic             is_put, evict, insert, promote;
   logic [AW-1:0]    slot, prom_age;
   logic             ram_we;
   logic [VALUE_W-1:0] ram_rdata;

   // sequencer: next state and handshake outputs
   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_RESP;
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // parallel search: entries below the count are valid, ranks are 0..count-1
   always_comb begin
      count_m1  = count_ff - 1'b1;
      srch_hit  = 1'b0;
      srch_slot = '0;
      srch_age  = '0;
      srch_lru  = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (CNTW'(i) < count_ff) begin
            if (key_ff[i] == item_ff.key) begin
               srch_hit  = 1'b1;
               srch_slot = srch_slot | AW'(i);
               srch_age  = srch_age | age_ff[i];
            end
            if (age_ff[i] == AW'(count_m1)) begin
               srch_lru = srch_lru | AW'(i);
            end
         end
      end
   end

   // capacity clamped to 1..MAX_ENTRIES
   always_comb begin
      cap_eff = WW'(capacity);
      if (cap_eff == '0) begin
         cap_eff = WW'(1);
      end
      if (cap_eff > WW'(MAX_ENTRIES)) begin
         cap_eff = WW'(MAX_ENTRIES);
      end
   end

   // execute-step decisions
   assign is_put   = (item_ff.op == OP_PUT);
   assign evict    = is_put && !hit_ff && full_ff;
   assign insert   = is_put && !hit_ff && !full_ff;
   assign promote  = hit_ff || evict;
   assign slot     = hit_ff ? hit_slot_ff : (evict ? lru_slot_ff : count_ff[AW-1:0]);
   assign prom_age = hit_ff ? hit_age_ff : AW'(count_m1);
   assign ram_we   = (state_ff == ST_EXEC) && is_put;

   // datapath next values
   always_comb begin
      item_in     = pop ? pop_item : item_ff;
      key_in      = key_ff;
      age_in      = age_ff;
      count_in    = count_ff;
      hit_in      = hit_ff;
      hit_slot_in = hit_slot_ff;
      hit_age_in  = hit_age_ff;
      lru_slot_in = lru_slot_ff;
      full_in     = full_ff;
      evict_in    = evict_ff;
      get_hit_in  = get_hit_ff;

      if (state_ff == ST_MATCH) begin
         hit_in      = srch_hit;
         hit_slot_in = srch_slot;
         hit_age_in  = srch_age;
         lru_slot_in = srch_lru;
         full_in     = (WW'(count_ff) >= cap_eff);
      end

      if (state_ff == ST_EXEC) begin
         // age every more recent entry (all of them on a plain insert)
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (CNTW'(i) < count_ff) begin
               if (insert || (promote && (age_ff[i] < prom_age))) begin
                  age_in[i] = age_ff[i] + 1'b1;
               end
            end
         end
         if (promote || insert) begin
            age_in[slot] = '0;
         end
         if (is_put && !hit_ff) begin
            key_in[slot] = item_ff.key;
         end
         if (insert) begin
            count_in = count_ff + 1'b1;
         end
         evict_in   = evict;
         get_hit_in = !is_put && hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      key_ff      <= key_in;
      age_ff      <= age_in;
      hit_ff      <= hit_in;
      hit_slot_ff <= hit_slot_in;
      hit_age_ff  <= hit_age_in;
      lru_slot_ff <= lru_slot_in;
      full_ff     <= full_in;
      evict_ff    <= evict_in;
      get_hit_ff  <= get_hit_in;
   end

   // value store: written on put, read for the response
   lkv_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ENTRIES)
   ) u_value_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot),
      .wdata (item_ff.value),
      .raddr (slot),
      .rdata (ram_rdata)
   );

   // response fields
   always_comb begin
      rsp_data.hit       = hit_ff;
      rsp_data.value_out = get_hit_ff ? ram_rdata : '0;
      rsp_data.evicted   = evict_ff;
   end

   assign count = count_ff;

endmodule

`default_nettype wire

[design/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative get/put store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// exactly one response, shown on rsp_data for a single cycle with rsp_valid
// high; the receiver cannot stall it, so it must take the response then.
// A taken request passes the holding stage and the request queue; the back end
// serves one request at a time while more are taken behind it: its
// sequencer walks search, execute and respond steps, and the value RAM read
// is registered. A one-deep holding stage and a two-entry queue
// keep three requests behind the one in service, so a burst of four requests
// is taken before busy rises. The user must write the capacity register only
// while no request is in flight; the block itself does not enforce this. 0 acts
// as 1, and values above MAX_ENTRIES act as MAX_ENTRIES.
`default_nettype none

`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache #(
   parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire lkv_pkg::lkv_req_type      req_data,
   output logic                           rsp_valid,
   output lkv_pkg::lkv_rsp_type           rsp_data,
   input  wire logic                      csr_write_en,
   input  wire logic [lkv_pkg::CAP_W-1:0] csr_write_data
);

   import lkv_pkg::*;

   localparam int CNTW = $clog2(MAX_ENTRIES + 1);

   logic [CAP_W-1:0] cap_ff, cap_in;
   lkv_qstat_type    q_stat;
   logic             push, pop;
   lkv_item_type     push_item, pop_item;
   logic [CNTW-1:0]  count;
   logic             rsp_evict, rsp_quiet, count_ok;

   // capacity register
   assign cap_in = csr_write_en ? csr_write_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   lkv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_item (push_item)
   );

   lkv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   lkv_back #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .capacity  (cap_ff),
      .q_stat    (q_stat),
      .pop_item  (pop_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .count     (count)
   );

   // checks
   assign rsp_evict = rsp_valid && rsp_data.evicted;
   assign rsp_quiet = !rsp_data.hit && (rsp_data.value_out == '0);
   assign count_ok  = (count <= CNTW'(MAX_ENTRIES));

   `LKV_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "response over two cycles")
   `LKV_ASSERT_IMP(a_evict_miss, clock, reset, rsp_evict, rsp_quiet, "eviction with hit or data")
   `LKV_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ok, "entry count above table size")

endmodule

`default_nettype wire

[tb/tb_lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and put requests through the start/busy handshake, rewrites the
// capacity register between phases while the cache is drained, and checks
// every response against a cycle-free LRU predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
   import lkv_pkg::*;

   localparam int SLOTS       = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int PRINT_LIMIT = 40;

   // scoreboard: LRU predictor plus the queue of predicted responses
   class lru_cache_scoreboard;
      bit               slot_valid[SLOTS];
      logic [31:0]      slot_key[SLOTS];
      logic [31:0]      slot_value[SLOTS];
      int unsigned      slot_age[SLOTS];
      int unsigned      entry_total;
      logic [CAP_W-1:0] capacity;
      lkv_rsp_type      expected_rsp[$];
      int               error_count;

      function new();
         foreach (slot_valid[i]) begin
            slot_valid[i] = 0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_age[i]   = 0;
         end
         entry_total = 0;
         capacity    = CAP_RESET;
         error_count = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         capacity = value;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      // 0 behaves as 1, anything above the slot count as the slot count
      function int unsigned usable_capacity();
         if (capacity == 0) return 1;
         if (capacity > SLOTS) return SLOTS;
         return capacity;
      endfunction

      // move a valid slot to the front of the recency order
      function void make_newest(int slot);
         int unsigned rank;
         rank = slot_age[slot];
         for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_age[i] < rank) slot_age[i]++;
         slot_age[slot] = 0;
      endfunction

      function lkv_rsp_type predict_response(lkv_req_type req);
         lkv_rsp_type rsp;
         bit          found;
         int          slot;
         int          oldest;
         int          free_slot;
         rsp       = '0;
         found     = 0;
         slot      = 0;
         oldest    = -1;
         free_slot = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (!found && slot_valid[i] && slot_key[i] == req.key) begin
               found = 1;
               slot  = i;
            end
         end
         rsp.hit = found;
         if (lkv_op_type'(req.opcode) == OP_GET) begin
            if (found) begin
               rsp.value_out = slot_value[slot];
               make_newest(slot);
            end
         end else if (found) begin
            slot_value[slot] = req.value_in;
            make_newest(slot);
         end else begin
            // full (or over a lowered capacity): drop the least recent entry
            if (entry_total >= usable_capacity()) begin
               for (int i = 0; i < SLOTS; i++)
                  if (slot_valid[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
                     oldest = i;
               if (oldest >= 0) begin
                  slot_valid[oldest] = 0;
                  if (entry_total > 0) entry_total--;
                  rsp.evicted = 1'b1;
               end
            end
            for (int i = 0; i < SLOTS; i++)
               if (free_slot < 0 && !slot_valid[i]) free_slot = i;
            if (free_slot >= 0) begin
               for (int i = 0; i < SLOTS; i++)
                  if (slot_valid[i]) slot_age[i]++;
               slot_valid[free_slot] = 1;
               slot_key[free_slot]   = req.key;
               slot_value[free_slot] = req.value_in;
               slot_age[free_slot]   = 0;
               entry_total++;
            end
         end
         return rsp;
      endfunction

      function void note_request(lkv_req_type req);
         expected_rsp = {expected_rsp, predict_response(req)};
      endfunction

      task report_mismatch(string what);
         if (error_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
         error_count++;
      endtask

      task check_response(lkv_rsp_type got);
         lkv_rsp_type want;
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("response with no request outstanding: %h", got));
            return;
         end
         want = expected_rsp.pop_front();
         if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
         if (got.value_out !== want.value_out)
            report_mismatch($sformatf("value_out %h, want %h", got.value_out,
                                      want.value_out));
         if (got.evicted !== want.evicted)
            report_mismatch($sformatf("evicted %b, want %b", got.evicted, want.evicted));
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   lkv_req_type         req_data;
   logic                rsp_valid;
   lkv_rsp_type         rsp_data;
   logic                csr_write_en;
   logic [CAP_W-1:0]    csr_write_data;

   lru_cache_scoreboard sb;
   logic [31:0]         key_pool[$];
   int                  stall_cycles;

   lru_key_value_cache i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // monitor and watchdog: everything is sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_valid) sb.check_response(rsp_data);
         if (start && !busy) sb.note_request(req_data);
         if (csr_write_en) sb.set_capacity(csr_write_data);
         if (rsp_valid || (start && !busy)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // mostly short gaps, now and then a long one
   function int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function lkv_req_type make_request(lkv_op_type op, logic [31:0] k, logic [31:0] v);
      lkv_req_type req;
      req.opcode   = op;
      req.key      = k;
      req.value_in = v;
      return req;
   endfunction

   // present one request at the falling edge and hold it until taken
   task issue(input lkv_req_type req, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // stop sending and wait until every request has been answered
   task wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task write_capacity(input logic [CAP_W-1:0] value);
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // random traffic over a small key pool so hits and evictions both happen
   task run_phase(input logic [CAP_W-1:0] cap, input int n_items);
      int unsigned pool_size;
      int unsigned usable;
      bit          burst;
      lkv_req_type req;
      write_capacity(cap);
      usable    = (cap == 0) ? 1 : ((cap > SLOTS) ? SLOTS : cap);
      pool_size = usable + $urandom_range(1, 4);
      key_pool.delete();
      repeat (pool_size) key_pool = {key_pool, 32'($urandom())};
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < n_items; n++) begin
         if ($urandom_range(0, 49) == 0) wait_drained();
         req.opcode   = ($urandom_range(0, 99) < 45) ? OP_GET : OP_PUT;
         req.key      = ($urandom_range(0, 9) == 0) ? $urandom()
                                                    : key_pool[$urandom_range(0, pool_size - 1)];
         req.value_in = $urandom();
         issue(req, burst ? 0 : draw_gap());
      end
   endtask

   initial begin
      logic [CAP_W-1:0] phase_caps[10];
      sb             = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extreme keys and values, hits, misses, update in place
      issue(make_request(OP_GET, 32'h0000_0000, 32'hDEAD_BEEF), 0);
      issue(make_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF), draw_gap());
      issue(make_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000), 0);
      issue(make_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF), draw_gap());
      issue(make_request(OP_PUT, 32'h0000_0000, 32'h0000_0000), 0);
      issue(make_request(OP_GET, 32'h8000_0000, 32'h0000_0000), 0);
      issue(make_request(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF), draw_gap());
      issue(make_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000), 0);
      issue(make_request(OP_GET, 32'h0000_0000, 32'h5555_5555), 0);
      issue(make_request(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678), draw_gap());
      issue(make_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000), 0);
      issue(make_request(OP_GET, 32'h0000_0001, 32'h0000_0000), 0);

      // capacity lowered below the entry count: each new key evicts one
      write_capacity(5'd2);
      issue(make_request(OP_PUT, 32'h0000_0001, 32'hAAAA_AAAA), 0);
      issue(make_request(OP_PUT, 32'h0000_0002, 32'h5555_5555), 0);
      issue(make_request(OP_PUT, 32'h0000_0001, 32'h0F0F_0F0F), 0);

      // zero capacity behaves as one entry
      write_capacity(5'd0);
      issue(make_request(OP_PUT, 32'h0000_0003, 32'hF0F0_F0F0), 0);
      issue(make_request(OP_GET, 32'h0000_0003, 32'h0000_0000), 0);
      issue(make_request(OP_GET, 32'h0000_0001, 32'h0000_0000), 0);

      // oversized capacity behaves as the full table
      write_capacity(5'd31);
      for (int k = 0; k < 4; k++)
         issue(make_request(OP_PUT, 32'h1000_0000 + k, $urandom()), 0);

      // random phases across the capacity range, extremes included
      phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd17, 5'd16, 5'd3, 5'd8};
      phase_caps[9] = CAP_W'($urandom_range(0, 31));
      foreach (phase_caps[p]) run_phase(phase_caps[p], 72);

      wait_drained();
      repeat (10) @(negedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
